// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLIES(name, clk, rst_n, a, b) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define CHK_NEXT(name, clk, rst_n, a, b) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define CHK_IMPLIES(name, clk, rst_n, a, b)
`define CHK_NEXT(name, clk, rst_n, a, b)
`endif
`endif

// ===== design/epd_pkg.sv =====
// Shared types, constants and helpers of the encoder position decoder.
package epd_pkg;
	localparam int NUM_W = 44;
	localparam int DEN_W = 48;
	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [22:0] SPD_K = 23'd6000000;
	localparam logic [12:0] PWM_K = 13'd4115;
	localparam logic [11:0] DEG_K = 12'd3600;
	localparam logic [11:0] ANG_MAX = 12'd3599;
	localparam logic [15:0] PER_MAX = 16'd65535;

	typedef enum logic [1:0] {FUNC_TICK, FUNC_EDGE, FUNC_ZPULSE, FUNC_ZERO} func_t;
	typedef enum logic [1:0] {SEL_SPD, SEL_ANG, SEL_PWM} div_sel_t;
	typedef enum logic {CFG_CPR, CFG_TIMEOUT} cfg_idx_t;

	typedef struct packed {
		logic     apply;
		logic     mul1;
		logic     mul2;
		logic     start;
		div_sel_t start_sel;
		logic     cap_spd;
		logic     cap_ang;
		logic     cap_pwm;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic spd_en;
		logic pwm_en;
		logic div_done;
		logic out_blocked;
	} sts_t;

	function automatic logic [31:0] sat_s32(input logic neg, input logic [NUM_W-1:0] mag);
		logic [31:0] r;
		if (neg) begin
			if (mag > NUM_W'(33'h080000000)) r = 32'h80000000;
			else r = 32'd0 - mag[31:0];
		end else begin
			if (mag > NUM_W'(32'h7FFFFFFF)) r = 32'h7FFFFFFF;
			else r = mag[31:0];
		end
		return r;
	endfunction
endpackage

// ===== design/epd_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module epd_div import epd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q, den_q, rem_nxt;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial, diff;
	logic             ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};
	assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule

// ===== design/epd_ctrl.sv =====
// Controller state machine that sequences event update, products and divisions.
module epd_ctrl import epd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output cmd_t cmd,
	input  sts_t sts
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL1, ST_MUL2, ST_DSPD, ST_DANG, ST_DPWM, ST_FIN
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.apply = 1'b1;
					state_nxt = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_nxt = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				cmd.start = 1'b1;
				if (sts.spd_en) begin
					cmd.start_sel = SEL_SPD;
					state_nxt = ST_DSPD;
				end else begin
					cmd.start_sel = SEL_ANG;
					state_nxt = ST_DANG;
				end
			end
			ST_DSPD: begin
				if (sts.div_done) begin
					cmd.cap_spd = 1'b1;
					cmd.start = 1'b1;
					cmd.start_sel = SEL_ANG;
					state_nxt = ST_DANG;
				end
			end
			ST_DANG: begin
				if (sts.div_done) begin
					cmd.cap_ang = 1'b1;
					if (sts.pwm_en) begin
						cmd.start = 1'b1;
						cmd.start_sel = SEL_PWM;
						state_nxt = ST_DPWM;
					end else begin
						state_nxt = ST_FIN;
					end
				end
			end
			ST_DPWM: begin
				if (sts.div_done) begin
					cmd.cap_pwm = 1'b1;
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!sts.out_blocked) begin
					cmd.load_out = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

	assign in_stall = (state_q != ST_IDLE);
endmodule

// ===== design/epd_dp.sv =====
// Datapath: decoder state, configuration, products, divider and result register.
module epd_dp import epd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         func,
	input  logic [31:0]        now_ms,
	input  logic [15:0]        timer_count,
	input  logic [15:0]        capture_value,
	input  logic               out_stall,
	output logic               out_valid,
	output logic signed [31:0] position,
	output logic signed [31:0] zeroed_count,
	output logic signed [15:0] pos_delta,
	output logic [15:0]        sample_period,
	output logic signed [31:0] speed_crpm,
	output logic signed [31:0] angle_ddeg,
	output logic [31:0]        index_count,
	output logic [31:0]        last_index_ms,
	output logic               pwm_ok,
	output logic [15:0]        pwm_period,
	output logic [15:0]        pwm_high,
	output logic [11:0]        pwm_angle
);
	logic [15:0] cpr_q, timeout_q;
	logic [31:0] total_q, zoff_q, time_now_q, edge_time_q, pulse_total_q, pulse_time_q;
	logic [31:0] speed_held_q, period_q;
	logic [15:0] prev_cnt_q, prev_delta_q, period_held_q, rise_q, per_meas_q, high_meas_q;
	logic        await_fall_q, seen_rise_q, duty_valid_q, spd_en_q, pwm_en_q, out_valid_q;

	logic [31:0] period_c, zeroed_c, zmag_c;
	logic [15:0] d16_c, dmag_c, diff_c, cpr_eff_c;

	logic [NUM_W-1:0] spd_num_q, ang_num_q, pwm_num_q;
	logic [DEN_W-1:0] spd_den_q;
	logic [28:0]      hi_q, pe4_q;
	logic             spd_neg_q, ang_neg_q;
	logic [31:0]      ang_q;
	logic [11:0]      pwm_ang_q;

	logic [NUM_W-1:0] div_num, quot;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [38:0]      spd_prod;
	logic [47:0]      den_prod;
	logic [43:0]      ang_prod;
	logic [28:0]      hi_prod, pe_prod, hi_diff;
	logic [40:0]      pwm_prod;

	assign period_c = now_ms - time_now_q;
	assign d16_c = timer_count - prev_cnt_q;
	assign diff_c = capture_value - rise_q;
	assign zeroed_c = total_q - zoff_q;
	assign zmag_c = zeroed_c[31] ? (32'd0 - zeroed_c) : zeroed_c;
	assign dmag_c = prev_delta_q[15] ? (16'd0 - prev_delta_q) : prev_delta_q;
	assign cpr_eff_c = (cpr_q == 16'd0) ? 16'd1 : cpr_q;

	assign spd_prod = dmag_c * SPD_K;
	assign den_prod = cpr_eff_c * period_q;
	assign ang_prod = zmag_c * DEG_K;
	assign hi_prod = high_meas_q * PWM_K;
	assign pe_prod = per_meas_q * PWM_K;
	assign hi_diff = hi_q - {13'd0, per_meas_q};
	assign pwm_prod = hi_diff * DEG_K;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q <= 16'd4096;
			timeout_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CPR: cpr_q <= cfg_data;
				CFG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decoder state, updated once per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0; zoff_q <= '0; time_now_q <= '0; edge_time_q <= '0;
			pulse_total_q <= '0; pulse_time_q <= '0; speed_held_q <= '0; period_q <= '0;
			prev_cnt_q <= '0; prev_delta_q <= '0; period_held_q <= '0; rise_q <= '0;
			per_meas_q <= '0; high_meas_q <= '0; await_fall_q <= 1'b0;
			seen_rise_q <= 1'b0; duty_valid_q <= 1'b0; spd_en_q <= 1'b0;
			pwm_en_q <= 1'b0; out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply) begin
				spd_en_q <= (func_t'(func) == FUNC_TICK) && (period_c != 32'd0);
				case (func_t'(func))
					FUNC_TICK: begin
						time_now_q <= now_ms;
						period_q <= period_c;
						period_held_q <= (period_c > {16'd0, PER_MAX}) ? PER_MAX
							: period_c[15:0];
						prev_cnt_q <= timer_count;
						prev_delta_q <= d16_c;
						total_q <= total_q + {{16{d16_c[15]}}, d16_c};
						if (duty_valid_q && ((now_ms - edge_time_q) > {16'd0, timeout_q}))
							duty_valid_q <= 1'b0;
					end
					FUNC_EDGE: begin
						edge_time_q <= time_now_q;
						if (!await_fall_q) begin
							if (seen_rise_q) per_meas_q <= diff_c;
							rise_q <= capture_value;
							seen_rise_q <= 1'b1;
							await_fall_q <= 1'b1;
						end else begin
							high_meas_q <= diff_c;
							await_fall_q <= 1'b0;
							if (diff_c != 16'd0 && per_meas_q > diff_c) duty_valid_q <= 1'b1;
						end
					end
					FUNC_ZPULSE: begin
						pulse_total_q <= pulse_total_q + 32'd1;
						pulse_time_q <= time_now_q;
					end
					FUNC_ZERO: zoff_q <= total_q;
					default: ;
				endcase
			end
			if (cmd.mul2)
				pwm_en_q <= duty_valid_q && (per_meas_q > high_meas_q)
					&& (hi_q > {13'd0, per_meas_q});
			if (cmd.cap_spd) speed_held_q <= sat_s32(spd_neg_q, quot);
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Operand products, division results and the output register.
	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			spd_num_q <= NUM_W'(spd_prod);
			spd_neg_q <= prev_delta_q[15];
			spd_den_q <= den_prod;
			ang_num_q <= ang_prod;
			ang_neg_q <= zeroed_c[31];
			hi_q <= hi_prod;
			pe4_q <= pe_prod;
		end
		if (cmd.mul2) begin
			pwm_num_q <= NUM_W'(pwm_prod);
			pwm_ang_q <= '0;
		end
		if (cmd.cap_ang) ang_q <= sat_s32(ang_neg_q, quot);
		if (cmd.cap_pwm)
			pwm_ang_q <= (quot > NUM_W'(ANG_MAX)) ? ANG_MAX : quot[11:0];
		if (cmd.load_out) begin
			position <= total_q;
			zeroed_count <= zeroed_c;
			pos_delta <= prev_delta_q;
			sample_period <= period_held_q;
			speed_crpm <= cmd.cap_spd ? sat_s32(spd_neg_q, quot) : speed_held_q;
			angle_ddeg <= ang_q;
			index_count <= pulse_total_q;
			last_index_ms <= pulse_time_q;
			pwm_ok <= duty_valid_q;
			pwm_period <= per_meas_q;
			pwm_high <= high_meas_q;
			pwm_angle <= pwm_ang_q;
		end
	end

	always_comb begin
		case (cmd.start_sel)
			SEL_SPD: begin div_num = spd_num_q; div_den = spd_den_q; end
			SEL_ANG: begin div_num = ang_num_q; div_den = {32'd0, cpr_eff_c}; end
			SEL_PWM: begin div_num = pwm_num_q; div_den = {19'd0, pe4_q}; end
			default: begin div_num = ang_num_q; div_den = {32'd0, cpr_eff_c}; end
		endcase
	end

	epd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (quot)
	);

	assign sts.spd_en = spd_en_q;
	assign sts.pwm_en = pwm_en_q;
	assign sts.div_done = div_done;
	assign sts.out_blocked = out_valid_q && out_stall;
	assign out_valid = out_valid_q;
endmodule

// ===== design/encoder_position_speed_pwm_decoder.sv =====
// A request is taken in ST_IDLE, the product states ST_MUL1 and ST_MUL2 follow, then one to three
// divisions run on the shared bit-serial divider, and the result is loaded in ST_FIN.
// No new request is taken until the previous one is loaded; in_stall is high meanwhile.
// A new request is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) clears all decoder state and loads the register defaults.
// Top level of the encoder position, speed and PWM angle decoder.
`include "assert_macros.svh"
module encoder_position_speed_pwm_decoder import epd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [31:0]        now_ms,
	input  logic [15:0]        timer_count,
	input  logic [15:0]        capture_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] position,
	output logic signed [31:0] zeroed_count,
	output logic signed [15:0] pos_delta,
	output logic [15:0]        sample_period,
	output logic signed [31:0] speed_crpm,
	output logic signed [31:0] angle_ddeg,
	output logic [31:0]        index_count,
	output logic [31:0]        last_index_ms,
	output logic               pwm_ok,
	output logic [15:0]        pwm_period,
	output logic [15:0]        pwm_high,
	output logic [11:0]        pwm_angle,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	epd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.sts     (sts)
	);

	epd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.now_ms        (now_ms),
		.timer_count   (timer_count),
		.capture_value (capture_value),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.position      (position),
		.zeroed_count  (zeroed_count),
		.pos_delta     (pos_delta),
		.sample_period (sample_period),
		.speed_crpm    (speed_crpm),
		.angle_ddeg    (angle_ddeg),
		.index_count   (index_count),
		.last_index_ms (last_index_ms),
		.pwm_ok        (pwm_ok),
		.pwm_period    (pwm_period),
		.pwm_high      (pwm_high),
		.pwm_angle     (pwm_angle)
	);

	`CHK_NEXT(a_busy_after_req, clk, arst_n, in_valid && !in_stall, in_stall)
	`CHK_IMPLIES(a_pwm_range, clk, arst_n, out_valid, pwm_angle <= ANG_MAX)
	`CHK_IMPLIES(a_pwm_needs_valid, clk, arst_n, out_valid && (pwm_angle != 12'd0), pwm_ok)
endmodule
